[design/ptw_pkg.sv]
// ============================================================================
// ptw_pkg: shared types and constants of the page table walker
// Field widths, store window size, status and page size codes, and the
// decoded command that travels from the front end to the walk engine.
// ============================================================================
package ptw_pkg;

    // Table store window: MEM_WORDS 64-bit words at physical byte 0 upward.
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Payload widths.
    localparam int IDX_W   = 12;
    localparam int WORD_W  = 64;
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FRAME_W = PA_W - 12;     // table or page frame number
    localparam int SLOT_W  = 9;             // entries per table: 512
    localparam int WIDX_W  = FRAME_W + SLOT_W;

    // Entry bits.
    localparam int PRESENT_BIT = 0;
    localparam int BIG_BIT     = 7;

    // Decoupling queue between front end and walk engine.
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 64;
    localparam int REG_IDX_LSB = 3;
    localparam logic REG_ROOT  = 1'b0;

    // Walk levels.
    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_1G   = 2'd1;
    localparam logic [1:0] LVL_2M   = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PS_4K = 2'd0,
        PS_2M = 2'd1,
        PS_1G = 2'd2
    } t_psize;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_WALK  = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              wr_ok;           // write index falls inside the store
        logic [IDX_W-1:0]  store_index;
        logic [WORD_W-1:0] entry_word;
        logic [VA_W-1:0]   virt_address;
    } t_cmd;

endpackage

[design/ptw_req_if.sv]
// ============================================================================
// ptw_req_if: request channel of the page table walker
// Valid/ready channel carrying one store write or one translation request.
// ============================================================================
interface ptw_req_if import ptw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [IDX_W-1:0]  store_index;
    logic [WORD_W-1:0] entry_word;
    logic [VA_W-1:0]   virt_address;

    modport source (output valid, output kind, output store_index,
                    output entry_word, output virt_address, input ready);
    modport sink   (input valid, input kind, input store_index,
                    input entry_word, input virt_address, output ready);
endinterface

[design/ptw_rsp_if.sv]
// ============================================================================
// ptw_rsp_if: response channel of the page table walker
// Valid/ready channel carrying one status, physical address and page size.
// ============================================================================
interface ptw_rsp_if import ptw_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic [PA_W-1:0] phys_address;
    logic [1:0]      map_size;

    modport source (output valid, output status, output phys_address,
                    output map_size, input ready);
    modport sink   (input valid, input status, input phys_address,
                    input map_size, output ready);
endinterface

[design/four_level_page_table_walker_core.sv]
// ============================================================================
// four_level_page_table_walker_core: four-level page table walker
// Front end decodes and queues requests; walk engine owns the table store.
// ============================================================================
// A store write is answered from idle through the response register; a
// translation runs a lookup and a check state per level read, and stops when
// an entry falls outside the store. The walk engine finishes one write per
// cycle while responses are taken; it takes no new command during a walk,
// since each level's store read depends on the entry read before it.
// Reset: synchronous, active low; clears queue, walk, response control, root.

module four_level_page_table_walker_core import ptw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ptw_req_if.sink            i_req,
    ptw_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);
    // Root table address register. Register index is the address bit above
    // the 8-byte register slot; anything other than the root reads as zero.
    // The table store itself is not cleared by reset.
    logic [PA_W-1:0] r_root;
    logic            cfg_wr;

    t_cmd            cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (cfg_wr && paddr[REG_IDX_LSB] == REG_ROOT) begin
            r_root <= pwdata[PA_W-1:0];
        end
    end

    assign prdata = (paddr[REG_IDX_LSB] == REG_ROOT) ? APB_DW'(r_root) : '0;

    // Front end: takes a transfer whenever its queue has room, even while
    // the walk engine is busy or a response waits to be taken.
    ptw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // Walk engine: executes commands in order, so a write is visible to
    // every translation that follows it. The response register sits here.
    ptw_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_root      (r_root),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );
endmodule

[design/ptw_ram.sv]
// ============================================================================
// ptw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without a read.
// ============================================================================
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/ptw_front.sv]
// ============================================================================
// ptw_front: request intake and decode
// Accepts requests, decodes them into commands and queues them for the walker.
// ============================================================================
module ptw_front import ptw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptw_req_if.sink   i_req,
    output t_cmd      o_cmd,
    output logic      o_cmd_valid,
    input  logic      i_cmd_pop
);
    t_cmd            r_q [QDEPTH];
    logic [QPW-1:0]  r_wp, n_wp;
    logic [QPW-1:0]  r_rp, n_rp;
    logic [QCW-1:0]  r_cnt, n_cnt;
    logic            push;
    logic            pop;
    t_cmd            dec;

    // Decode: operation and whether a write lands inside the store window.
    always_comb begin
        dec.op           = i_req.kind ? OP_WALK : OP_WRITE;
        dec.wr_ok        = 32'(i_req.store_index) < 32'(MEM_WORDS);
        dec.store_index  = i_req.store_index;
        dec.entry_word   = i_req.entry_word;
        dec.virt_address = i_req.virt_address;
    end

    assign i_req.ready = r_cnt != QCW'(QDEPTH);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = r_cnt != '0;

`ifndef SYNTHESIS
    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == QCW'(QDEPTH)) |-> (r_wp == r_rp))
        else $error("queue count disagrees with pointers");
`endif
endmodule

[design/ptw_walk.sv]
// ============================================================================
// ptw_walk: walk engine
// Executes queued commands: store writes and four-level table walks.
// ============================================================================
module ptw_walk import ptw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PA_W-1:0]   i_root,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    ptw_rsp_if.source         o_rsp
);
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_CHECK  = 3'b100
    } t_walk_state;

    t_walk_state          r_state, n_state;
    logic [1:0]           r_level, n_level;
    logic [FRAME_W-1:0]   r_base, n_base;
    logic [VA_W-1:0]      r_va, n_va;

    logic                 r_out_valid;
    t_status              r_status;
    logic [PA_W-1:0]      r_pa;
    t_psize               r_size;

    logic                 can_emit;
    logic                 emit;
    t_status              e_status;
    logic [PA_W-1:0]      e_pa;
    t_psize               e_size;

    logic [SLOT_W-1:0]    slot;
    logic [WIDX_W-1:0]    widx;
    logic                 in_win;
    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_W-1:0]    entry;
    logic                 present;
    logic                 big;
    logic                 done;

    ptw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (MEM_AW'(i_cmd.store_index)),
        .i_wdata (i_cmd.entry_word),
        .i_re    (ram_re),
        .i_raddr (widx[MEM_AW-1:0]),
        .o_rdata (entry)
    );

    // Slot of the current level, then the word index of the entry.
    always_comb begin
        case (r_level)
            LVL_TOP: slot = r_va[47:39];
            LVL_1G:  slot = r_va[38:30];
            LVL_2M:  slot = r_va[29:21];
            default: slot = r_va[20:12];
        endcase
    end

    assign widx    = {r_base, slot};
    assign in_win  = widx < WIDX_W'(MEM_WORDS);
    assign present = entry[PRESENT_BIT];
    assign big     = entry[BIG_BIT];
    assign done    = !present || r_level == LVL_LEAF
                     || (big && (r_level == LVL_1G || r_level == LVL_2M));

    assign can_emit = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_base    = r_base;
        n_va      = r_va;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_pa      = '0;
        e_size    = PS_4K;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_WALK) begin
                        o_cmd_pop = 1'b1;
                        n_va      = i_cmd.virt_address;
                        n_base    = i_root[PA_W-1:12];
                        n_level   = LVL_TOP;
                        n_state   = S_LOOKUP;
                    end else if (can_emit) begin
                        o_cmd_pop = 1'b1;
                        ram_we    = i_cmd.wr_ok;
                        emit      = 1'b1;
                        e_status  = ST_WRITTEN;
                    end
                end
            end
            S_LOOKUP: begin
                if (!in_win) begin
                    if (can_emit) begin
                        emit     = 1'b1;
                        e_status = ST_OUTSIDE;
                        n_state  = S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (done) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                        if (!present) begin
                            e_status = ST_ABSENT;
                        end else if (r_level == LVL_1G) begin
                            e_pa   = {entry[PA_W-1:30], r_va[29:0]};
                            e_size = PS_1G;
                        end else if (r_level == LVL_2M) begin
                            e_pa   = {entry[PA_W-1:21], r_va[20:0]};
                            e_size = PS_2M;
                        end else begin
                            e_pa   = {entry[PA_W-1:12], r_va[11:0]};
                        end
                    end
                end else begin
                    n_base  = entry[PA_W-1:12];
                    n_level = r_level + 1'b1;
                    n_state = S_LOOKUP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        r_base  <= n_base;
        r_va    <= n_va;
        if (emit) begin
            r_status <= e_status;
            r_pa     <= e_pa;
            r_size   <= e_size;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.phys_address = r_pa;
    assign o_rsp.map_size     = r_size;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_pa == '0 && r_size == PS_4K))
        else $error("failed or write result carries an address or size");
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> ($past(r_state) == S_LOOKUP
                                  || $past(r_state) == S_CHECK))
        else $error("entry checked without a store read");
    a_no_pop_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == S_IDLE)
        else $error("command taken while a walk is in progress");
    a_leaf_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && e_size != PS_4K) |-> (r_level == LVL_1G || r_level == LVL_2M))
        else $error("large page reported at a level that cannot map one");
`endif
endmodule

[test/four_level_page_table_walker_core_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// four_level_page_table_walker_core_test: self-checking walker testbench
// Loads table words through the request channel, sets the root register over
// the APB port and checks every response against a shadow copy of the tables
// that is walked level by level in the testbench.
// ============================================================================
module four_level_page_table_walker_core_test;
    import ptw_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 30;      // longer than the slowest walk
    localparam int TABLE_FRAMES = MEM_WORDS >> SLOT_W;
    localparam logic [APB_AW-1:0] ROOT_ADDR =
        {{(APB_AW-1){1'b0}}, REG_ROOT} << REG_IDX_LSB;

    // One response as the walker must return it.
    typedef struct {
        t_status           status;
        logic [PA_W-1:0]   phys_address;
        t_psize            map_size;
    } t_translation;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ptw_req_if req_if ();
    ptw_rsp_if rsp_if ();

    four_level_page_table_walker_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the table store and the root register. A word may only be
    // walked through once its written flag is set, because the store comes
    // out of reset with undefined contents.
    logic [WORD_W-1:0] shadow_tables  [MEM_WORDS];
    bit                shadow_written [MEM_WORDS];
    logic [PA_W-1:0]   root_reg;

    t_translation translations_due [$];

    int  items_sent;
    int  mismatches;
    int  cycle_count;
    bit  send_gaps_on;
    bit  recv_gaps_on;
    int  rsp_hold_cycles;

    // ------------------------------------------------------------------------
    // Clock, reset and cycle watchdog.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction. The walk runs on the shadow store exactly as the block does:
    // slot indices from VA bits 47:39, 38:30, 29:21 and 20:12, next table
    // frame from entry bits 51:12, and a stop on an entry that is missing,
    // lies outside the store or maps a large page at the middle levels.
    // ------------------------------------------------------------------------
    function automatic t_translation translate_va(logic [VA_W-1:0] va);
        t_translation       r;
        logic [FRAME_W-1:0] frame;
        logic [WIDX_W-1:0]  wi;
        logic [WORD_W-1:0]  e;
        r.status       = ST_OK;
        r.phys_address = '0;
        r.map_size     = PS_4K;
        frame          = root_reg[PA_W-1:12];
        for (int lvl = LVL_TOP; lvl <= LVL_LEAF; lvl++) begin
            wi = {frame, va[(39 - 9*lvl) +: SLOT_W]};
            if (wi >= MEM_WORDS) begin
                r.status = ST_OUTSIDE;
                return r;
            end
            e = shadow_tables[wi[MEM_AW-1:0]];
            if (!e[PRESENT_BIT]) begin
                r.status = ST_ABSENT;
                return r;
            end
            // Bit 7 only means a large page at the 1GB and 2MB levels; on the
            // top level and on the leaf it is simply ignored.
            if (lvl == LVL_1G && e[BIG_BIT]) begin
                r.phys_address = {e[PA_W-1:30], va[29:0]};
                r.map_size     = PS_1G;
                return r;
            end
            if (lvl == LVL_2M && e[BIG_BIT]) begin
                r.phys_address = {e[PA_W-1:21], va[20:0]};
                r.map_size     = PS_2M;
                return r;
            end
            frame = e[PA_W-1:12];
        end
        r.phys_address = {frame, va[11:0]};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle gaps: most are zero or short, a few are long.
    // ------------------------------------------------------------------------
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Inputs change on the falling edge; a transfer is seen on
    // the rising edge where valid and ready are both high, and only then does
    // the shadow store change and the expected response get queued.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_op op, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] word,
                             input logic [VA_W-1:0] va);
        int           gap;
        t_translation r;
        gap = send_gaps_on ? idle_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= op;
        req_if.store_index  <= idx;
        req_if.entry_word   <= word;
        req_if.virt_address <= va;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        items_sent++;
        if (op == OP_WRITE) begin
            // A write past the store would change nothing but still answer.
            if (idx < MEM_WORDS) begin
                shadow_tables[idx]  = word;
                shadow_written[idx] = 1'b1;
            end
            r.status       = ST_WRITTEN;
            r.phys_address = '0;
            r.map_size     = PS_4K;
        end else begin
            r = translate_va(va);
        end
        translations_due.push_back(r);
    endtask

    // Stops offering and waits until every queued response has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (translations_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Root register write over APB: setup cycle, then access cycle. It is
    // only done with the walker idle, so the drain comes first.
    task automatic config_root(input logic [APB_DW-1:0] value);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROOT_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        root_reg = value[PA_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random table content. Most entries are present pointers into one of the
    // frames that the store covers, so walks go deep; the rest are missing
    // entries, pointers past the store and large pages. Flag bits and the
    // bits above 51 are random throughout.
    // ------------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] make_entry(int lvl);
        logic [WORD_W-1:0] e;
        int                roll;
        e    = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            e[PRESENT_BIT] = 1'b0;
            return e;
        end
        e[PRESENT_BIT] = 1'b1;
        if (lvl == LVL_LEAF)
            return e;
        if (roll < 14) begin
            if (e[PA_W-1:12] < TABLE_FRAMES)
                e[PA_W-1] = 1'b1;
        end else if (roll < 35 && (lvl == LVL_1G || lvl == LVL_2M)) begin
            e[BIG_BIT] = 1'b1;
        end else begin
            e[PA_W-1:12] = FRAME_W'($urandom_range(0, TABLE_FRAMES - 1));
            if (lvl == LVL_1G || lvl == LVL_2M)
                e[BIG_BIT] = 1'b0;
        end
        return e;
    endfunction

    // Slot indices favor the first and last slots and a few low ones, so
    // that walks share tables; a quarter of them are fully random.
    function automatic logic [VA_W-1:0] random_va();
        logic [VA_W-1:0] va;
        va = VA_W'({$urandom, $urandom});
        for (int lvl = LVL_TOP; lvl <= LVL_LEAF; lvl++) begin
            case ($urandom_range(0, 3))
                0:       va[(39 - 9*lvl) +: SLOT_W] = SLOT_W'($urandom);
                1:       va[(39 - 9*lvl) +: SLOT_W] = '0;
                2:       va[(39 - 9*lvl) +: SLOT_W] = '1;
                default: va[(39 - 9*lvl) +: SLOT_W] = SLOT_W'($urandom_range(1, 3));
            endcase
        end
        return va;
    endfunction

    // Follows the walk for va on the shadow store and writes a fresh entry
    // wherever the walk would reach a word that was never loaded; then sends
    // the translation itself.
    task automatic build_and_translate(input logic [VA_W-1:0] va);
        logic [FRAME_W-1:0] frame;
        logic [WIDX_W-1:0]  wi;
        logic [WORD_W-1:0]  e;
        bit                 done;
        frame = root_reg[PA_W-1:12];
        done  = 1'b0;
        for (int lvl = LVL_TOP; lvl <= LVL_LEAF && !done; lvl++) begin
            wi = {frame, va[(39 - 9*lvl) +: SLOT_W]};
            if (wi >= MEM_WORDS) begin
                done = 1'b1;
            end else begin
                if (!shadow_written[wi[MEM_AW-1:0]])
                    send_item(OP_WRITE, wi[IDX_W-1:0], make_entry(lvl),
                              VA_W'({$urandom, $urandom}));
                e     = shadow_tables[wi[MEM_AW-1:0]];
                done  = !e[PRESENT_BIT] ||
                        ((lvl == LVL_1G || lvl == LVL_2M) && e[BIG_BIT]);
                frame = e[PA_W-1:12];
            end
        end
        send_item(OP_WALK, IDX_W'($urandom), {$urandom, $urandom}, va);
    endtask

    // Random traffic: mostly built walks, with a share of stray writes that
    // overwrite random store words with random content.
    task automatic random_traffic(input int count, input int noise_pct);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(OP_WRITE, IDX_W'($urandom), {$urandom, $urandom},
                          VA_W'({$urandom, $urandom}));
            else
                build_and_translate(random_va());
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side. Ready changes on the falling edge with random stalls,
    // or stays low for a requested hold-off counted down here.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                rsp_hold_cycles--;
            end else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = recv_gaps_on ? idle_gap() : 0;
            end
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Each response transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_translation want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (translations_due.size() == 0) begin
                note_mismatch("response transfer with nothing outstanding");
            end else begin
                want = translations_due.pop_front();
                if (rsp_if.status !== want.status ||
                    rsp_if.phys_address !== want.phys_address ||
                    rsp_if.map_size !== want.map_size)
                    note_mismatch($sformatf(
                        "status exp %0d got %0d, phys exp %h got %h, size exp %0d got %0d",
                        want.status, rsp_if.status, want.phys_address,
                        rsp_if.phys_address, want.map_size, rsp_if.map_size));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Hand-built tables in frames 0 to 3 reach every page size and every way
    // a walk can stop. The root carries junk in its low 12 bits, which must
    // be ignored. The top-level entry and the leaf both have bit 7 set, which
    // must not turn them into large pages.
    task automatic test_directed_walks();
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
        config_root(64'h0000_0000_0000_0ABC);
        send_item(OP_WRITE, 12'd0,    {12'h000, 40'd1, 12'h081}, '0);
        send_item(OP_WRITE, 12'd512,  {12'h000, 40'd2, 12'h001}, '0);
        send_item(OP_WRITE, 12'd1024, {12'h000, 40'd3, 12'h001}, '0);
        send_item(OP_WRITE, 12'd1536, {12'hFFF, 40'hFF_FFFF_FFFF, 12'h081}, '0);
        send_item(OP_WALK,  '0, '0, 48'h0000_0000_0FFF);
        // 1GB page in the last slot of the second-level table.
        send_item(OP_WRITE, 12'd1023, {12'hA5A, 40'h5A_5A5A_5A5A, 12'h081}, '0);
        send_item(OP_WALK,  '0, '0, 48'h007F_FFFF_FFFF);
        // 2MB page in the last slot of the third-level table.
        send_item(OP_WRITE, 12'd1535, {12'h000, 40'h12_3456_789A, 12'h0FF}, '0);
        send_item(OP_WALK,  '0, '0, 48'h0000_3FFF_FFFF);
        // Missing leaf, then a missing third-level entry with every other bit set.
        send_item(OP_WRITE, 12'd1537, 64'h0, '0);
        send_item(OP_WALK,  '0, '0, 48'h0000_0000_1000);
        send_item(OP_WRITE, 12'd1025, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        send_item(OP_WALK,  '0, '0, 48'h0000_0020_0000);
        // Second-level pointer to a frame past the store.
        send_item(OP_WRITE, 12'd513,  {12'h000, 40'h100, 12'h001}, '0);
        send_item(OP_WALK,  '0, '0, 48'h0000_4000_0000);
        // Missing top-level entry, reached with the all-ones address.
        send_item(OP_WRITE, 12'd511,  64'h0, '0);
        send_item(OP_WALK,  '0, '0, 48'hFFFF_FFFF_FFFF);
        send_item(OP_WRITE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        // A root past the store stops every walk at the top level.
        config_root(64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_WALK,  '0, '0, 48'h0);
        send_item(OP_WALK,  '0, '0, 48'hFFFF_FFFF_FFFF);
        // Root on the last frame: the last store word is all ones, so the
        // top level follows it and the next level falls outside.
        config_root(64'h0000_0000_0000_7FFF);
        send_item(OP_WALK,  '0, '0, 48'hFFFF_FFFF_FFFF);
    endtask

    // Deep random walks under several roots, with and without idling.
    task automatic test_random_translation();
        config_root(64'h0);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        random_traffic(350, 5);
        config_root(64'hFFF0_0000_0000_7123);
        recv_gaps_on = 1'b0;
        random_traffic(300, 5);
        config_root({12'($urandom), 37'd0, 3'($urandom_range(0, TABLE_FRAMES - 1)),
                     12'($urandom)});
        send_gaps_on = 1'b0;
        random_traffic(250, 5);
    endtask

    // Heavy stray writes scramble tables between walks.
    task automatic test_store_noise();
        config_root({12'($urandom), 37'd0, 3'($urandom_range(0, TABLE_FRAMES - 1)),
                     12'($urandom)});
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        random_traffic(150, 40);
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the queue fills and the request channel must stall.
    task automatic test_output_stall();
        config_root(64'h0000_0000_0000_2000);
        send_gaps_on    = 1'b0;
        recv_gaps_on    = 1'b1;
        rsp_hold_cycles = 300;
        random_traffic(80, 10);
    endtask

    // Short bursts, each followed by a full drain, so the walker restarts
    // from idle many times.
    task automatic test_drain_and_resume();
        config_root(64'h0000_0000_0000_5000);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        for (int burst = 0; burst < 8; burst++) begin
            random_traffic(15, 10);
            wait_drained();
        end
    endtask

    // The largest frame-aligned root lies past the store: every walk stops
    // at once, and stray writes still land.
    task automatic test_root_outside();
        config_root(64'h000F_FFFF_FFFF_F000);
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        random_traffic(25, 20);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_if.valid        = 1'b0;
        req_if.kind         = OP_WRITE;
        req_if.store_index  = '0;
        req_if.entry_word   = '0;
        req_if.virt_address = '0;
        root_reg            = '0;
        items_sent          = 0;
        mismatches          = 0;
        cycle_count         = 0;
        send_gaps_on        = 1'b0;
        recv_gaps_on        = 1'b0;
        rsp_hold_cycles     = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_walks();
        test_random_translation();
        test_store_noise();
        test_output_stall();
        test_drain_and_resume();
        test_root_outside();

        // Everything answered; give a stray late response time to show up.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
design/ptw_pkg.sv
design/ptw_req_if.sv
design/ptw_rsp_if.sv
design/ptw_ram.sv
design/ptw_front.sv
design/ptw_walk.sv
design/four_level_page_table_walker_core.sv
test/four_level_page_table_walker_core_test.sv
